// File: hw/rtl/phtc_pkg.sv
// Shared types and constants for the per-host traffic counter table.
// Holds the token word that walks the cell chain and the field widths.
// No dependencies.
package phtc_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int MAX_DEPTH       = 1024;
  localparam int FILL_W          = 11;   // holds 0..MAX_DEPTH
  localparam int SLOT_W          = 7;
  localparam int ADDR_W          = 32;
  localparam int BYTES_W         = 48;
  localparam int PKTS_W          = 32;
  localparam int LEN_W           = 16;
  localparam int ETYPE_W         = 16;
  localparam int HOSTS_W         = 8;
  localparam int IN_DATA_W       = 104;
  localparam int OUT_DATA_W      = 208;

  localparam logic [ETYPE_W-1:0] IPV4_TYPE = 16'h0800;

  // Item operation codes (carried in in_tuser).
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Request/result word handed from cell to cell.
  typedef struct packed {
    logic                valid;
    logic                frame;     // IPv4 frame to account
    logic                rd;        // table read
    logic [ADDR_W-1:0]   src;
    logic [ADDR_W-1:0]   dst;
    logic [LEN_W-1:0]    len;
    logic [SLOT_W-1:0]   rslot;
    logic [FILL_W-1:0]   fill;      // occupied slots so far
    logic                src_ok;
    logic [SLOT_W-1:0]   src_slot;
    logic                dst_ok;
    logic [SLOT_W-1:0]   dst_slot;
    logic                ent_ok;
    logic [ADDR_W-1:0]   ent_addr;
    logic [BYTES_W-1:0]  ent_tx;
    logic [BYTES_W-1:0]  ent_rx;
    logic [PKTS_W-1:0]   ent_pkts;
    logic [LEN_W-1:0]    ent_peak;
  } token_t;

endpackage

// File: hw/rtl/phtc_cell.sv
// One table slot of the per-host traffic counter chain.
// Holds one host entry, updates it from the passing word, registers the word.
// Depends on phtc_pkg.
module phtc_cell #(
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  phtc_pkg::token_t tok_in,
  output phtc_pkg::token_t tok_out
);

  localparam logic [phtc_pkg::FILL_W-1:0] IDX = phtc_pkg::FILL_W'(INDEX);

  logic [phtc_pkg::ADDR_W-1:0]  addr_r,  addr_nxt;
  logic [phtc_pkg::BYTES_W-1:0] tx_r,    tx_nxt;
  logic [phtc_pkg::BYTES_W-1:0] rx_r,    rx_nxt;
  logic [phtc_pkg::PKTS_W-1:0]  pkts_r,  pkts_nxt;
  logic [phtc_pkg::LEN_W-1:0]   peak_r,  peak_nxt;
  logic                         ent_we;

  logic                         tok_valid_r;
  phtc_pkg::token_t             tok_r, tok_nxt;

  logic occ, alloc, src_hit, dst_hit;
  logic [phtc_pkg::BYTES_W-1:0] base_tx, base_rx;
  logic [phtc_pkg::PKTS_W-1:0]  base_pkts;
  logic [phtc_pkg::LEN_W-1:0]   base_peak;

  always_comb begin
    occ   = IDX < tok_in.fill;
    // first free slot takes the source if unseen, else the destination
    alloc = tok_in.frame && (IDX == tok_in.fill) && !(tok_in.src_ok && tok_in.dst_ok);
    src_hit = tok_in.frame && !tok_in.src_ok &&
              ((occ && addr_r == tok_in.src) || alloc);
    dst_hit = tok_in.frame && !tok_in.dst_ok &&
              ((occ && addr_r == tok_in.dst) ||
               (alloc && (tok_in.src_ok || tok_in.dst == tok_in.src)));

    base_tx   = alloc ? '0 : tx_r;
    base_rx   = alloc ? '0 : rx_r;
    base_pkts = alloc ? '0 : pkts_r;
    base_peak = alloc ? '0 : peak_r;

    addr_nxt = alloc ? (tok_in.src_ok ? tok_in.dst : tok_in.src) : addr_r;
    tx_nxt   = base_tx + (src_hit ? phtc_pkg::BYTES_W'(tok_in.len) : '0);
    rx_nxt   = base_rx + (dst_hit ? phtc_pkg::BYTES_W'(tok_in.len) : '0);
    pkts_nxt = base_pkts + phtc_pkg::PKTS_W'(src_hit) + phtc_pkg::PKTS_W'(dst_hit);
    peak_nxt = (tok_in.len > base_peak) ? tok_in.len : base_peak;
    ent_we   = tok_in.valid && (src_hit || dst_hit);

    tok_nxt = tok_in;
    if (src_hit) begin
      tok_nxt.src_ok   = 1'b1;
      tok_nxt.src_slot = IDX[phtc_pkg::SLOT_W-1:0];
    end
    if (dst_hit) begin
      tok_nxt.dst_ok   = 1'b1;
      tok_nxt.dst_slot = IDX[phtc_pkg::SLOT_W-1:0];
    end
    if (alloc) begin
      tok_nxt.fill = tok_in.fill + 1'b1;
    end
    // capture the entry for a read of an occupied slot
    if (tok_in.rd && occ && (phtc_pkg::FILL_W'(tok_in.rslot) == IDX)) begin
      tok_nxt.ent_ok   = 1'b1;
      tok_nxt.ent_addr = addr_r;
      tok_nxt.ent_tx   = tx_r;
      tok_nxt.ent_rx   = rx_r;
      tok_nxt.ent_pkts = pkts_r;
      tok_nxt.ent_peak = peak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      addr_r <= addr_nxt;
      tx_r   <= tx_nxt;
      rx_r   <= rx_nxt;
      pkts_r <= pkts_nxt;
      peak_r <= peak_nxt;
    end
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = tok_valid_r;
  end

endmodule

// File: hw/rtl/per_host_traffic_counters_core.sv
// Top level of the per-host traffic counter table: input/result channels,
// the chain of phtc_cell slots and the result register.
// Depends on phtc_pkg and phtc_cell.
//
// Use:
//   Input channel in_*: one word per item. in_tuser selects the operation:
//   account a captured frame, or read back one table slot. Frames whose
//   ethertype is not IPv4 pass through without touching the table.
//   Result channel out_*: exactly one word per input word, in order.
//   Path: the word walks the chain one slot per cycle, registered in every
//   slot, and the finished result is then loaded into the output register.
//   Flow: one item in flight; in_tready rises again at the same edge
//   that loads the result into the output register.
//   Stall: a result the receiver has not taken holds in out_tdata; the next
//   result finished meanwhile waits in a hold register, and the input
//   stays closed until it can move on.
//   Reset: the occupied-slot count, the chain and both channels go empty;
//   entry contents are not cleared, slots above the count are never read.
module per_host_traffic_counters_core #(
  parameter int TABLE_DEPTH = phtc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // ethertype[15:0], source_address[47:16], dest_address[79:48],
  // frame_length[95:80], read_slot[102:96], zero pad [103]
  input  logic [phtc_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // frame_counted[0], source_slot[7:1], source_slot_ok[8], dest_slot[15:9],
  // dest_slot_ok[16], entry_valid[17], entry_address[49:18],
  // entry_tx_bytes[97:50], entry_rx_bytes[145:98], entry_packets[177:146],
  // entry_peak_length[193:178], hosts_in_use[201:194], zero pad [207:202]
  output logic [phtc_pkg::OUT_DATA_W-1:0] out_tdata
);

  phtc_pkg::token_t chain [0:TABLE_DEPTH];
  phtc_pkg::token_t tail;

  logic                              busy_r, busy_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [phtc_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                              hold_valid_r, hold_valid_nxt;
  logic [phtc_pkg::OUT_DATA_W-1:0]   hold_data_r, hold_data_nxt;
  logic [phtc_pkg::FILL_W-1:0]       slots_used_r, slots_used_nxt;
  logic [phtc_pkg::OUT_DATA_W-1:0]   tail_word;
  logic                              in_acc, out_free;

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && !busy_r;

  // Build the request word from the input fields.
  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = in_acc;
    chain[0].frame    = (in_tuser == phtc_pkg::OP_FRAME) &&
                        (in_tdata[15:0] == phtc_pkg::IPV4_TYPE);
    chain[0].rd       = (in_tuser == phtc_pkg::OP_READ);
    chain[0].src      = in_tdata[47:16];
    chain[0].dst      = in_tdata[79:48];
    chain[0].len      = in_tdata[95:80];
    chain[0].rslot    = in_tdata[102:96];
    chain[0].fill     = slots_used_r;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
    phtc_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  // Pack the finished word into result layout.
  always_comb begin
    tail_word          = '0;
    tail_word[0]       = tail.frame;
    tail_word[7:1]     = tail.src_slot;
    tail_word[8]       = tail.src_ok;
    tail_word[15:9]    = tail.dst_slot;
    tail_word[16]      = tail.dst_ok;
    tail_word[17]      = tail.ent_ok;
    tail_word[49:18]   = tail.ent_addr;
    tail_word[97:50]   = tail.ent_tx;
    tail_word[145:98]  = tail.ent_rx;
    tail_word[177:146] = tail.ent_pkts;
    tail_word[193:178] = tail.ent_peak;
    tail_word[201:194] = tail.fill[phtc_pkg::HOSTS_W-1:0];
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    busy_nxt       = busy_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;
    slots_used_nxt = slots_used_r;

    if (in_acc) begin
      busy_nxt = 1'b1;
    end
    if (tail.valid) begin
      slots_used_nxt = tail.fill;
    end

    if (hold_valid_r && out_free) begin
      // advance the waiting result
      out_valid_nxt  = 1'b1;
      out_data_nxt   = hold_data_r;
      hold_valid_nxt = 1'b0;
      busy_nxt       = 1'b0;
    end else if (tail.valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = tail_word;
      busy_nxt      = 1'b0;
    end else if (tail.valid) begin
      // receiver stalled: park the result
      hold_valid_nxt = 1'b1;
      hold_data_nxt  = tail_word;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
      slots_used_r <= '0;
    end else begin
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
      slots_used_r <= slots_used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    hold_data_r <= hold_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/phtc_checker.sv
// Port-level checks for the per-host traffic counter table.
// Watches the top-level channels only; bound to per_host_traffic_counters_core.
// Depends on nothing else.
module phtc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [207:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one item in flight: input closes after an accepted word
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input open with an item in flight");

  // a counted frame carries no read entry
  a_frame_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[17])
    else $error("frame result shows a read entry");

  // a source slot that was not granted reads as zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:1] == 7'd0)
    else $error("source slot set without a grant");

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind per_host_traffic_counters_core phtc_checker u_phtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
